### rtl/core/pp_token_boundary_tagger_top_defines.svh
// assertion macros used by the token tagger lexer
`ifndef PP_TOKEN_BOUNDARY_TAGGER_TOP_DEFINES_SVH
`define PP_TOKEN_BOUNDARY_TAGGER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PPTB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PPTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPTB_ASSERT_SAME(lbl, ante, cons, msg)
`define PPTB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/pptb_pkg.sv
// types, codes and character tables for the token tagger
`default_nettype none
package pptb_pkg;

  localparam int CpWidth = 21;
  typedef logic [CpWidth-1:0] cp_t;

  // token kinds
  localparam logic [2:0] KindWhite   = 3'd0;
  localparam logic [2:0] KindNewline = 3'd1;
  localparam logic [2:0] KindComment = 3'd2;
  localparam logic [2:0] KindPunct   = 3'd3;
  localparam logic [2:0] KindIdent   = 3'd4;
  localparam logic [2:0] KindNumber  = 3'd5;
  localparam logic [2:0] KindUnknown = 3'd6;
  localparam logic [2:0] KindEnd     = 3'd7;

  localparam cp_t ChNewline = 21'h0a;
  localparam cp_t ChSlash   = 21'h2f;
  localparam cp_t ChDot     = 21'h2e;
  localparam cp_t ChQuote   = 21'h27;
  localparam cp_t ChStar    = 21'h2a;

  // universal-character ranges allowed in identifiers
  localparam int NumRanges = 30;
  localparam cp_t RangeLo [NumRanges] = '{
    21'ha8,   21'haa,   21'had,   21'haf,   21'hb2,   21'hb7,   21'hbc,   21'hc0,
    21'hd8,   21'hf8,   21'h100,  21'h1681, 21'h180f, 21'h200b, 21'h202a, 21'h203f,
    21'h2054, 21'h2060, 21'h2070, 21'h2460, 21'h2776, 21'h2c00, 21'h2e80, 21'h3004,
    21'h3021, 21'h3031, 21'hf900, 21'hfd40, 21'hfdf0, 21'hfe47
  };
  localparam cp_t RangeHi [NumRanges] = '{
    21'ha8,   21'haa,   21'had,   21'haf,   21'hb5,   21'hba,   21'hbe,   21'hd6,
    21'hf6,   21'hff,   21'h167f, 21'h180d, 21'h1fff, 21'h200d, 21'h202e, 21'h2040,
    21'h2054, 21'h206f, 21'h218f, 21'h24ff, 21'h2793, 21'h2dff, 21'h2fff, 21'h3007,
    21'h302f, 21'hd7ff, 21'hfd3d, 21'hfdcf, 21'hfe44, 21'hfffd
  };

  // character class flags
  typedef struct packed {
    logic nl;
    logic slash;
    logic dot;
    logic star;
    logic quote;
    logic sign;
    logic white;
    logic punct;
    logic digit;
    logic basic;
    logic id_char;
    logic id_first;
    logic exp_letter;
  } pptb_cls_t;

  // one tagged result
  typedef struct packed {
    cp_t        ch;
    logic [2:0] kind;
    logic       start;
    logic       last;
  } pptb_res_t;

  // results of one step toward the output queue
  typedef struct packed {
    logic [1:0] n;
    pptb_res_t  res0;
    pptb_res_t  res1;
  } pptb_push_t;

endpackage
`default_nettype wire

### rtl/core/pptb_classify.sv
// character class decode for one code point
`default_nettype none
module pptb_classify
  import pptb_pkg::*;
(
  input  wire cp_t       code_point,
  output pptb_cls_t      cls
);

  logic wide;
  logic mark;
  logic range_hit;

  always_comb begin
    range_hit = 1'b0;
    for (int i = 0; i < NumRanges; i++) begin
      if (code_point >= RangeLo[i] && code_point <= RangeHi[i]) begin
        range_hit = 1'b1;
      end
    end
    // planes 1 to 14 minus the last two code points of each plane
    wide = range_hit ||
           (code_point >= 21'h10000 && code_point <= 21'hefffd &&
            code_point[15:0] <= 16'hfffd);
    // combining marks may not start an identifier
    mark = (code_point >= 21'h300  && code_point <= 21'h36f)  ||
           (code_point >= 21'h1dc0 && code_point <= 21'h1dff) ||
           (code_point >= 21'h20d0 && code_point <= 21'h20ff) ||
           (code_point >= 21'hfe20 && code_point <= 21'hfe2f);

    cls.nl    = code_point == ChNewline;
    cls.slash = code_point == ChSlash;
    cls.dot   = code_point == ChDot;
    cls.star  = code_point == ChStar;
    cls.quote = code_point == ChQuote;
    cls.sign  = code_point == 21'h2b || code_point == 21'h2d;
    cls.white = code_point == 21'h20 || code_point == 21'h09 ||
                code_point == 21'h0b || code_point == 21'hff;
    cls.punct = code_point == 21'h28 || code_point == 21'h29 ||
                code_point == 21'h5b || code_point == 21'h5d ||
                code_point == 21'h7b || code_point == 21'h7d ||
                code_point == 21'h3b;
    cls.digit = code_point >= 21'h30 && code_point <= 21'h39;
    cls.basic = (code_point >= 21'h41 && code_point <= 21'h5a) ||
                code_point == 21'h5f ||
                (code_point >= 21'h61 && code_point <= 21'h7a);
    cls.id_char    = cls.basic || cls.digit || wide;
    cls.id_first   = cls.id_char && !cls.digit && !mark;
    cls.exp_letter = code_point == 21'h65 || code_point == 21'h45 ||
                     code_point == 21'h70 || code_point == 21'h50;
  end

endmodule
`default_nettype wire

### rtl/core/pptb_lexer.sv
// lexer state and result generation, one step per item
`default_nettype none
`include "pp_token_boundary_tagger_top_defines.svh"
module pptb_lexer
  import pptb_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             step,
  input  wire cp_t        code_point,
  input  wire             end_of_input,
  input  wire pptb_cls_t  cls,
  output pptb_push_t      push
);

  localparam logic [2:0] ModeIdle   = 3'd0;
  localparam logic [2:0] ModeIdent  = 3'd1;
  localparam logic [2:0] ModeNum    = 3'd2;
  localparam logic [2:0] ModeLineC  = 3'd3;
  localparam logic [2:0] ModeBlockC = 3'd4;
  localparam logic [2:0] ModeSlash  = 3'd5;
  localparam logic [2:0] ModeDot    = 3'd6;
  localparam logic [2:0] ModeQuote  = 3'd7;

  // the held character follows from the mode alone
  logic [2:0] mode_r, mode_nxt;
  logic       exp_r, exp_nxt;
  logic       star_r, star_nxt;

  logic       bt_emit;
  logic [2:0] bt_mode;
  pptb_res_t  bt_res;
  pptb_res_t  res0, res1;
  logic [1:0] n;

  function automatic pptb_res_t mk(cp_t ch, logic [2:0] kind, logic start);
    pptb_res_t r;
    r.ch    = ch;
    r.kind  = kind;
    r.start = start;
    r.last  = 1'b0;
    return r;
  endfunction

  // between-token decode of the current character
  always_comb begin
    bt_emit = 1'b1;
    bt_mode = ModeIdle;
    bt_res  = mk(code_point, KindUnknown, 1'b1);
    if (cls.nl) begin
      bt_res.kind = KindNewline;
    end else if (cls.slash) begin
      bt_emit = 1'b0;
      bt_mode = ModeSlash;
    end else if (cls.dot) begin
      bt_emit = 1'b0;
      bt_mode = ModeDot;
    end else if (cls.white) begin
      bt_res.kind = KindWhite;
    end else if (cls.punct) begin
      bt_res.kind = KindPunct;
    end else if (cls.digit) begin
      bt_res.kind = KindNumber;
      bt_mode     = ModeNum;
    end else if (cls.id_first) begin
      bt_res.kind = KindIdent;
      bt_mode     = ModeIdent;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    exp_nxt  = exp_r;
    star_nxt = star_r;
    res0     = mk(code_point, KindComment, 1'b0);
    res1     = bt_res;
    n        = 2'd0;
    if (end_of_input) begin
      mode_nxt = ModeIdle;
      exp_nxt  = 1'b0;
      star_nxt = 1'b0;
      res1     = mk('0, KindEnd, 1'b1);
      n        = 2'd2;
      if (mode_r == ModeSlash) begin
        res0 = mk(ChSlash, KindPunct, 1'b1);
      end else if (mode_r == ModeDot) begin
        res0 = mk(ChDot, KindPunct, 1'b1);
      end else if (mode_r == ModeQuote) begin
        res0 = mk(ChQuote, KindUnknown, 1'b1);
      end else begin
        res0 = mk('0, KindEnd, 1'b1);
        n    = 2'd1;
      end
    end else begin
      case (mode_r)
        ModeSlash: begin
          if (cls.slash || cls.star) begin
            res0     = mk(ChSlash, KindComment, 1'b1);
            res1     = mk(code_point, KindComment, 1'b0);
            n        = 2'd2;
            mode_nxt = cls.slash ? ModeLineC : ModeBlockC;
            if (cls.star) begin
              star_nxt = 1'b0;
            end
          end else begin
            res0     = mk(ChSlash, KindPunct, 1'b1);
            n        = bt_emit ? 2'd2 : 2'd1;
            mode_nxt = bt_mode;
            exp_nxt  = 1'b0;
          end
        end
        ModeDot: begin
          if (cls.digit) begin
            res0     = mk(ChDot, KindNumber, 1'b1);
            res1     = mk(code_point, KindNumber, 1'b0);
            n        = 2'd2;
            mode_nxt = ModeNum;
            exp_nxt  = 1'b0;
          end else begin
            res0     = mk(ChDot, KindPunct, 1'b1);
            n        = bt_emit ? 2'd2 : 2'd1;
            mode_nxt = bt_mode;
            exp_nxt  = 1'b0;
          end
        end
        ModeQuote: begin
          if (cls.digit || cls.basic) begin
            res0     = mk(ChQuote, KindNumber, 1'b0);
            res1     = mk(code_point, KindNumber, 1'b0);
            n        = 2'd2;
            mode_nxt = ModeNum;
            exp_nxt  = cls.exp_letter;
          end else begin
            res0     = mk(ChQuote, KindUnknown, 1'b1);
            n        = bt_emit ? 2'd2 : 2'd1;
            mode_nxt = bt_mode;
            exp_nxt  = 1'b0;
          end
        end
        ModeLineC: begin
          n = 2'd1;
          if (cls.nl) begin
            res0     = mk(code_point, KindNewline, 1'b1);
            mode_nxt = ModeIdle;
          end
        end
        ModeBlockC: begin
          n = 2'd1;
          if (star_r && cls.slash) begin
            mode_nxt = ModeIdle;
            star_nxt = 1'b0;
          end else begin
            star_nxt = cls.star;
          end
        end
        ModeIdent: begin
          if (cls.id_char) begin
            res0 = mk(code_point, KindIdent, 1'b0);
            n    = 2'd1;
          end else begin
            res0     = bt_res;
            n        = {1'b0, bt_emit};
            mode_nxt = bt_mode;
            exp_nxt  = 1'b0;
          end
        end
        ModeNum: begin
          if (exp_r && cls.sign) begin
            res0    = mk(code_point, KindNumber, 1'b0);
            n       = 2'd1;
            exp_nxt = 1'b0;
          end else if (cls.id_char || cls.dot) begin
            res0    = mk(code_point, KindNumber, 1'b0);
            n       = 2'd1;
            exp_nxt = cls.exp_letter;
          end else if (cls.quote) begin
            mode_nxt = ModeQuote;
            exp_nxt  = 1'b0;
          end else begin
            res0     = bt_res;
            n        = {1'b0, bt_emit};
            mode_nxt = bt_mode;
            exp_nxt  = 1'b0;
          end
        end
        default: begin
          res0     = bt_res;
          n        = {1'b0, bt_emit};
          mode_nxt = bt_mode;
          exp_nxt  = 1'b0;
        end
      endcase
    end
    // mark the final result of this item
    if (n == 2'd1) begin
      res0.last = 1'b1;
    end else if (n == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeIdle;
      exp_r  <= 1'b0;
      star_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      exp_r  <= exp_nxt;
      star_r <= star_nxt;
    end
  end

  assign push.n    = step ? n : 2'd0;
  assign push.res0 = res0;
  assign push.res1 = res1;

  `PPTB_ASSERT_SAME(a_pair_last, push.n == 2'd2, push.res1.last && !push.res0.last, "last flag misplaced on result pair")
  `PPTB_ASSERT_NEXT(a_end_resets, step && end_of_input, mode_r == ModeIdle && !exp_r && !star_r, "state not cleared after end")
  `PPTB_ASSERT_NEXT(a_quote_from_num, step && mode_nxt == ModeQuote, $past(mode_r) == ModeNum, "quote hold entered outside a number")

endmodule
`default_nettype wire

### rtl/core/pptb_outq.sv
// four-entry result queue, up to two writes and one read per cycle
`default_nettype none
module pptb_outq
  import pptb_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire pptb_push_t push,
  output logic            room,
  output logic            out_valid,
  input  wire             out_ready,
  output pptb_res_t       out_res
);

  pptb_res_t  mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_res   = mem_r[rp_r];
  assign room      = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push.n;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push.n} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/core/pp_token_boundary_tagger_top.sv
// top level of the preprocessing-token boundary tagger
//
//  channel | dir | tdata                 | tuser                          | tlast
//  in_     | in  | [20:0] code_point     | [0] end_of_input               | -
//  out_    | out | [20:0] char_out       | [2:0] token_kind,[3] token_start | last_of_run
//
// one request a cycle enters while each yields at most one result and the output
// takes results; a request that yields two results (held slash, dot or separator
// resolved, or end of input with a held character) writes both to the queue at once
// a request is held in the input register, then the lexer step writes its results
// into the result queue; the lexer steps only while the queue has room for two entries,
// so the output side can stall freely and the input side stalls behind it
// synchronous active-low reset returns lexer to between tokens, queue empty
`default_nettype none
module pp_token_boundary_tagger_top
  import pptb_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  wire  [0:0]  in_tuser,   // [0] end_of_input
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [20:0] char_out, [23:21] zero
  output logic [3:0]  out_tuser,  // [2:0] token_kind, [3] token_start
  output logic        out_tlast   // last_of_run
);

  // input register
  logic       in_v_r;
  cp_t        in_cp_r;
  logic       in_eoi_r;
  logic       step;
  logic       room;
  pptb_cls_t  cls;
  pptb_push_t push;
  pptb_res_t  res;

  // lexer steps when an item is held and the queue can take two results
  assign step      = in_v_r && room;
  assign in_tready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cp_r  <= in_tdata[CpWidth-1:0];
      in_eoi_r <= in_tuser[0];
    end
  end

  pptb_classify u_classify (
    .code_point (in_cp_r),
    .cls        (cls)
  );

  pptb_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .code_point   (in_cp_r),
    .end_of_input (in_eoi_r),
    .cls          (cls),
    .push         (push)
  );

  pptb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'b000, res.ch};
  assign out_tuser = {res.start, res.kind};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

### verif/pp_token_boundary_tagger_top_tb.sv
// self-checking stream testbench for the preprocessing-token boundary tagger
module pp_token_boundary_tagger_top_tb;
  import pptb_pkg::*;

  // lexer states of the predictor
  localparam logic [3:0] ModeIdle     = 4'd0;
  localparam logic [3:0] ModeIdent    = 4'd1;
  localparam logic [3:0] ModeNumber   = 4'd2;
  localparam logic [3:0] ModeLineCmt  = 4'd3;
  localparam logic [3:0] ModeBlockCmt = 4'd4;
  localparam logic [3:0] ModeSlash    = 4'd5;
  localparam logic [3:0] ModeDot      = 4'd6;
  localparam logic [3:0] ModeQuote    = 4'd7;

  localparam cp_t ChTab   = 21'h09;
  localparam cp_t ChVtab  = 21'h0b;
  localparam cp_t ChSpace = 21'h20;
  localparam cp_t ChPlus  = 21'h2b;
  localparam cp_t ChMinus = 21'h2d;
  localparam cp_t ChNbsp  = 21'hff;
  localparam cp_t CpMax   = 21'h1fffff;

  localparam int GapPct        = 16;
  localparam int HoldOffCycles = 300;
  localparam int RandomItems   = 750;
  localparam int DrainCycles   = 8;

  typedef struct packed {
    cp_t        ch;
    logic [2:0] kind;
    logic       start;
    logic       last;
  } char_tag_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;
  wire  [3:0]  out_tuser;
  wire         out_tlast;

  // lexer state as the predictor sees it
  cp_t        held_cp      = '0;
  logic [3:0] lex_mode     = ModeIdle;
  logic       after_exp    = 1'b0;
  logic       star_pending = 1'b0;

  char_tag_t   expected_tags[$];
  int unsigned mismatch_count  = 0;
  int unsigned items_sent      = 0;
  bit          gaps_on         = 1'b1;
  bit          stalls_on       = 1'b1;
  int unsigned hold_offs_asked = 0;
  int unsigned hold_offs_done  = 0;
  int unsigned hold_left       = 0;

  pp_token_boundary_tagger_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // character classes
  function automatic bit in_span(cp_t c, cp_t lo, cp_t hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic bit is_decimal(cp_t c);
    return in_span(c, 21'h30, 21'h39);
  endfunction

  function automatic bit is_plain_letter(cp_t c);
    return in_span(c, 21'h41, 21'h5a) || c == 21'h5f || in_span(c, 21'h61, 21'h7a);
  endfunction

  // universal characters allowed in identifiers; adjacent spans merged
  function automatic bit is_wide(cp_t c);
    return c == 21'ha8 || c == 21'haa || c == 21'had || c == 21'haf
        || in_span(c, 21'hb2, 21'hb5) || in_span(c, 21'hb7, 21'hba)
        || in_span(c, 21'hbc, 21'hbe) || in_span(c, 21'hc0, 21'hd6)
        || in_span(c, 21'hd8, 21'hf6) || in_span(c, 21'hf8, 21'h167f)
        || in_span(c, 21'h1681, 21'h180d) || in_span(c, 21'h180f, 21'h1fff)
        || in_span(c, 21'h200b, 21'h200d) || in_span(c, 21'h202a, 21'h202e)
        || in_span(c, 21'h203f, 21'h2040) || c == 21'h2054
        || in_span(c, 21'h2060, 21'h218f) || in_span(c, 21'h2460, 21'h24ff)
        || in_span(c, 21'h2776, 21'h2793) || in_span(c, 21'h2c00, 21'h2dff)
        || in_span(c, 21'h2e80, 21'h2fff) || in_span(c, 21'h3004, 21'h3007)
        || in_span(c, 21'h3021, 21'h302f) || in_span(c, 21'h3031, 21'hd7ff)
        || in_span(c, 21'hf900, 21'hfd3d) || in_span(c, 21'hfd40, 21'hfdcf)
        || in_span(c, 21'hfdf0, 21'hfe44) || in_span(c, 21'hfe47, 21'hfffd)
        // supplementary planes 1 to 14 minus the two noncharacters at each plane end
        || (in_span(c, 21'h10000, 21'hefffd) && c[15:0] <= 16'hfffd);
  endfunction

  function automatic bit is_id_char(cp_t c);
    return is_plain_letter(c) || is_decimal(c) || is_wide(c);
  endfunction

  // combining marks continue an identifier but cannot begin one
  function automatic bit is_id_first(cp_t c);
    return is_id_char(c) && !is_decimal(c)
        && !in_span(c, 21'h300, 21'h36f) && !in_span(c, 21'h1dc0, 21'h1dff)
        && !in_span(c, 21'h20d0, 21'h20ff) && !in_span(c, 21'hfe20, 21'hfe2f);
  endfunction

  function automatic bit is_exp(cp_t c);
    return c == "e" || c == "E" || c == "p" || c == "P";
  endfunction

  function automatic bit is_white(cp_t c);
    return c == ChSpace || c == ChTab || c == ChVtab || c == ChNbsp;
  endfunction

  function automatic bit is_punct(cp_t c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}"
        || c == ";";
  endfunction

  function automatic void emit(cp_t ch, logic [2:0] kind, logic start);
    char_tag_t t;
    t = '{ch: ch, kind: kind, start: start, last: 1'b0};
    expected_tags.insert(expected_tags.size(), t);
  endfunction

  // character seen between tokens
  function automatic void start_token(cp_t c);
    lex_mode  = ModeIdle;
    after_exp = 1'b0;
    if (c == ChNewline) begin
      emit(c, KindNewline, 1'b1);
    end else if (c == ChSlash) begin
      held_cp  = c;
      lex_mode = ModeSlash;
    end else if (c == ChDot) begin
      held_cp  = c;
      lex_mode = ModeDot;
    end else if (is_white(c)) begin
      emit(c, KindWhite, 1'b1);
    end else if (is_punct(c)) begin
      emit(c, KindPunct, 1'b1);
    end else if (is_decimal(c)) begin
      lex_mode = ModeNumber;
      emit(c, KindNumber, 1'b1);
    end else if (is_id_first(c)) begin
      lex_mode = ModeIdent;
      emit(c, KindIdent, 1'b1);
    end else begin
      emit(c, KindUnknown, 1'b1);
    end
  endfunction

  // one accepted request: append its tagged characters to expected_tags
  function automatic void lex_step(cp_t c, logic eoi);
    cp_t         h;
    int unsigned first_new;
    char_tag_t   tag;
    h         = held_cp;
    first_new = expected_tags.size();
    if (eoi) begin
      if (lex_mode == ModeSlash || lex_mode == ModeDot) begin
        emit(h, KindPunct, 1'b1);
      end else if (lex_mode == ModeQuote) begin
        emit(h, KindUnknown, 1'b1);
      end
      emit('0, KindEnd, 1'b1);
      held_cp      = '0;
      lex_mode     = ModeIdle;
      after_exp    = 1'b0;
      star_pending = 1'b0;
    end else begin
      held_cp = '0;
      case (lex_mode)
        ModeSlash: begin
          if (c == ChSlash || c == ChStar) begin
            emit(h, KindComment, 1'b1);
            emit(c, KindComment, 1'b0);
            lex_mode     = (c == ChSlash) ? ModeLineCmt : ModeBlockCmt;
            star_pending = 1'b0;
          end else begin
            emit(h, KindPunct, 1'b1);
            start_token(c);
          end
        end
        ModeDot: begin
          if (is_decimal(c)) begin
            emit(h, KindNumber, 1'b1);
            emit(c, KindNumber, 1'b0);
            lex_mode  = ModeNumber;
            after_exp = 1'b0;
          end else begin
            emit(h, KindPunct, 1'b1);
            start_token(c);
          end
        end
        ModeQuote: begin
          // separator only counts when a digit or basic letter follows
          if (is_decimal(c) || is_plain_letter(c)) begin
            emit(h, KindNumber, 1'b0);
            emit(c, KindNumber, 1'b0);
            lex_mode  = ModeNumber;
            after_exp = is_exp(c);
          end else begin
            emit(h, KindUnknown, 1'b1);
            start_token(c);
          end
        end
        ModeLineCmt: begin
          if (c == ChNewline) begin
            emit(c, KindNewline, 1'b1);
            lex_mode = ModeIdle;
          end else begin
            emit(c, KindComment, 1'b0);
          end
        end
        ModeBlockCmt: begin
          // the star of the opener never arms the close
          emit(c, KindComment, 1'b0);
          if (star_pending && c == ChSlash) begin
            lex_mode     = ModeIdle;
            star_pending = 1'b0;
          end else begin
            star_pending = (c == ChStar);
          end
        end
        ModeIdent: begin
          if (is_id_char(c)) begin
            emit(c, KindIdent, 1'b0);
          end else begin
            start_token(c);
          end
        end
        ModeNumber: begin
          if (after_exp && (c == ChPlus || c == ChMinus)) begin
            emit(c, KindNumber, 1'b0);
            after_exp = 1'b0;
          end else if (is_id_char(c) || c == ChDot) begin
            emit(c, KindNumber, 1'b0);
            after_exp = is_exp(c);
          end else if (c == ChQuote) begin
            held_cp   = c;
            lex_mode  = ModeQuote;
            after_exp = 1'b0;
          end else begin
            start_token(c);
          end
        end
        default: begin
          start_token(c);
        end
      endcase
    end
    if (expected_tags.size() > first_new) begin
      tag      = expected_tags.pop_back();
      tag.last = 1'b1;
      expected_tags.insert(expected_tags.size(), tag);
    end
  endfunction

  // random characters
  function automatic cp_t pick_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return cp_t'(21'h41 + r);
    if (r < 52) return cp_t'(21'h61 + r - 26);
    return cp_t'(21'h5f);
  endfunction

  function automatic cp_t pick_digit();
    return cp_t'(21'h30 + $urandom_range(0, 9));
  endfunction

  function automatic cp_t pick_exp();
    case ($urandom_range(0, 3))
      0:       return cp_t'("e");
      1:       return cp_t'("E");
      2:       return cp_t'("p");
      default: return cp_t'("P");
    endcase
  endfunction

  // identifier ranges, combining marks and their near misses
  function automatic cp_t pick_wide();
    case ($urandom_range(0, 7))
      0:       return cp_t'($urandom_range(21'h80, 21'h167f));
      1:       return cp_t'($urandom_range(21'h3031, 21'hd7ff));
      2:       return cp_t'({$urandom_range(1, 14), 16'($urandom)});
      3:       return cp_t'($urandom_range(21'h300, 21'h36f));
      4:       return cp_t'($urandom_range(21'h20d0, 21'h20ff));
      5:       return cp_t'($urandom_range(21'hfe20, 21'hfe2f));
      6:       return cp_t'({$urandom_range(0, 16), 15'h7fff, 1'($urandom)});
      default: return cp_t'($urandom_range(21'h1dc0, 21'h1dff));
    endcase
  endfunction

  function automatic cp_t pick_ident_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return pick_letter();
    if (r < 75) return pick_digit();
    return pick_wide();
  endfunction

  function automatic cp_t pick_any();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return cp_t'($urandom_range(0, CpMax));
    if (r < 80) return cp_t'($urandom_range(0, 127));
    return pick_wide();
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_item(input cp_t cp, input logic eoi);
    if (gaps_on && $urandom_range(0, 99) < GapPct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, cp};
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_step(cp, eoi);
    items_sent++;
  endtask

  // output side: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_offs_done != hold_offs_asked) begin
      out_tready     <= 1'b0;
      hold_left      <= HoldOffCycles - 1;
      hold_offs_done <= hold_offs_done + 1;
    end else if (stalls_on) begin
      out_tready <= ($urandom_range(0, 99) >= GapPct);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    char_tag_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tags.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("mismatch: unexpected result char %h kind %0d start %b last %b",
                   out_tdata, out_tuser[2:0], out_tuser[3], out_tlast);
        end
        mismatch_count++;
      end else begin
        want = expected_tags.pop_front();
        if (out_tdata != {3'b000, want.ch} || out_tuser != {want.start, want.kind}
            || out_tlast != want.last) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected char %h kind %0d start %b last %b, got %h %0d %b %b",
                     want.ch, want.kind, want.start, want.last,
                     out_tdata, out_tuser[2:0], out_tuser[3], out_tlast);
          end
          mismatch_count++;
        end
      end
    end
  end

  // block comment whose opener star cannot close it, newline inside, then line comment
  task automatic test_comments();
    send_item(ChSlash, 1'b0);
    send_item(ChStar, 1'b0);
    send_item(ChSlash, 1'b0);
    send_item(ChNewline, 1'b0);
    send_item(ChStar, 1'b0);
    send_item(ChSlash, 1'b0);
    send_item(ChSlash, 1'b0);
    send_item(ChSlash, 1'b0);
    send_item(ChNewline, 1'b0);
  endtask

  // number from a full stop, signed exponent, separator with no digit after
  task automatic test_numbers();
    send_item(ChDot, 1'b0);
    send_item("5", 1'b0);
    send_item("e", 1'b0);
    send_item(ChPlus, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(";", 1'b0);
  endtask

  // combining mark at and after identifier start, code point extremes, 0xff as blank
  task automatic test_idents_and_extremes();
    send_item(21'h300, 1'b0);
    send_item("a", 1'b0);
    send_item(21'h300, 1'b0);
    send_item(CpMax, 1'b0);
    send_item(21'h10ffff, 1'b0);
    send_item('0, 1'b0);
    send_item(ChNbsp, 1'b0);
  endtask

  // end of input with a held slash, full stop and separator
  task automatic test_end_flush();
    send_item(ChSlash, 1'b0);
    send_item('0, 1'b1);
    send_item(ChDot, 1'b0);
    send_item('0, 1'b1);
    send_item("1", 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(CpMax, 1'b1);
  endtask

  // output held off while full stops and digits keep coming: queue fills, input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_offs_asked++;
    repeat (20) begin
      send_item(ChDot, 1'b0);
      send_item(pick_digit(), 1'b0);
    end
    send_item('0, 1'b1);
    gaps_on = 1'b1;
  endtask

  // mostly well-formed tokens with random content, plus noise and cut-off sequences
  task automatic test_random_stream();
    int unsigned base;
    int unsigned n;
    int unsigned done_cnt;
    bit          quiet;
    cp_t         c;
    base = items_sent;
    while (items_sent - base < RandomItems) begin
      // a stretch with no gaps and no stalls on either side
      done_cnt  = items_sent - base;
      quiet     = done_cnt >= 300 && done_cnt < 450;
      gaps_on   = !quiet;
      stalls_on = !quiet;
      n         = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
        0, 1: begin
          send_item(($urandom_range(0, 3) == 0) ? pick_wide() : pick_letter(), 1'b0);
          repeat (n) send_item(pick_ident_char(), 1'b0);
        end
        2, 3: begin
          if ($urandom_range(0, 3) == 0) send_item(ChDot, 1'b0);
          send_item(pick_digit(), 1'b0);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: send_item(pick_digit(), 1'b0);
              4:          send_item(pick_letter(), 1'b0);
              5:          send_item(ChDot, 1'b0);
              6: begin
                send_item(pick_exp(), 1'b0);
                send_item($urandom_range(0, 1) ? ChPlus : ChMinus, 1'b0);
              end
              7: begin
                send_item(ChQuote, 1'b0);
                send_item($urandom_range(0, 1) ? pick_digit() : pick_any(), 1'b0);
              end
              8:          send_item(pick_ident_char(), 1'b0);
              default: begin
                send_item(pick_exp(), 1'b0);
                send_item(ChQuote, 1'b0);
                send_item(pick_letter(), 1'b0);
              end
            endcase
          end
        end
        4: begin
          send_item(ChSlash, 1'b0);
          send_item(ChSlash, 1'b0);
          repeat (n) send_item(pick_any(), 1'b0);
          send_item(ChNewline, 1'b0);
        end
        5: begin
          send_item(ChSlash, 1'b0);
          send_item(ChStar, 1'b0);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0:       c = ChStar;
              1:       c = ChSlash;
              2:       c = ChNewline;
              default: c = pick_any();
            endcase
            send_item(c, 1'b0);
          end
          send_item(ChStar, 1'b0);
          send_item(ChSlash, 1'b0);
        end
        6: begin
          case ($urandom_range(0, 13))
            0:       c = ChSpace;
            1:       c = ChTab;
            2:       c = ChVtab;
            3:       c = ChNbsp;
            4:       c = ChNewline;
            5:       c = "(";
            6:       c = ")";
            7:       c = "[";
            8:       c = "]";
            9:       c = "{";
            10:      c = "}";
            11:      c = ";";
            12:      c = ChSlash;
            default: c = ChDot;
          endcase
          send_item(c, 1'b0);
        end
        7: begin
          repeat ($urandom_range(1, 3)) send_item(pick_any(), 1'b0);
        end
        8: begin
          send_item(cp_t'($urandom_range(0, CpMax)), 1'b1);
        end
        default: begin
          // sequence cut off by end of input
          case ($urandom_range(0, 3))
            0: send_item(ChSlash, 1'b0);
            1: send_item(ChDot, 1'b0);
            2: begin
              send_item(pick_digit(), 1'b0);
              send_item(ChQuote, 1'b0);
            end
            default: begin
              send_item(ChSlash, 1'b0);
              send_item(ChStar, 1'b0);
              repeat (n) send_item(pick_any(), 1'b0);
            end
          endcase
          send_item(cp_t'($urandom_range(0, CpMax)), 1'b1);
        end
      endcase
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_item('0, 1'b1);
  endtask

  initial begin : main_flow
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_comments();
    test_numbers();
    test_idents_and_extremes();
    test_end_flush();
    test_backpressure();
    test_random_stream();
    in_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pp_token_boundary_tagger_top_tb: done, clean");
    end else begin
      $display("pp_token_boundary_tagger_top_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #200000;
    $display("pp_token_boundary_tagger_top_tb: done, errors");
    $finish;
  end

endmodule
